/* design/ultrasonic_echo_ranger_defines.svh */
// Assertion macros shared by the ultrasonic echo ranger modules.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define URE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define URE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ure_pkg.sv */
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies.
`timescale 1ns / 1ps

package ure_pkg;

  // Field widths
  localparam int DUR_W    = 16;
  localparam int FILT_W   = 17;
  localparam int DIST_W   = 19;
  localparam int PERIOD_W = 16;
  localparam int SCHED_W  = 8;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMER_PERIOD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_SCHED  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRIG_WIDTH   = 2'd2;

  // Register reset values
  localparam logic [PERIOD_W-1:0] TIMER_PERIOD_RST = 16'd10000;
  localparam logic [SCHED_W-1:0]  PULSE_SCHED_RST  = 8'd5;
  localparam logic [SCHED_W-1:0]  TRIG_WIDTH_RST   = 8'd10;

  // Duration saturation limit in microseconds
  localparam logic [DUR_W-1:0] DUR_MAX = 16'hFFFF;

  // Distance = floor(D * 32000 / 7347) in 1/256 cm
  localparam int PROD_W  = 31;
  localparam int RECIP_W = 32;
  localparam int RECIP_SHIFT = 44;
  localparam int REM_W   = 32;
  localparam logic [14:0]        DIST_NUM   = 15'd32000;
  localparam logic [12:0]        DIST_DEN   = 13'd7347;
  // floor(2^44 / 7347); estimate is low by at most one
  localparam logic [RECIP_W-1:0] DIST_RECIP = 32'd2394472035;

  // Per-stage load enables of the distance pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

endpackage

/* design/ure_ctrl.sv */
// Configuration registers, microsecond counter and trigger scheduler.
// Depends on ure_pkg and ultrasonic_echo_ranger_defines.svh.
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_defines.svh"

module ure_ctrl import ure_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  step,
  output logic [TIME_WIDTH-1:0] usec,
  output logic                  trig
);

  logic [PERIOD_W-1:0]   timer_period_r;
  logic [SCHED_W-1:0]    pulse_sched_r;
  logic [SCHED_W-1:0]    trig_width_r;
  logic [TIME_WIDTH-1:0] usec_r;
  logic [PERIOD_W-1:0]   period_r, period_nxt, period_inc;
  logic [SCHED_W-1:0]    sched_r, sched_nxt;
  logic [SCHED_W-1:0]    pulse_r, pulse_nxt, pulse_ld;
  logic                  sched_step, fire;

  // Configuration writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_period_r <= TIMER_PERIOD_RST;
      pulse_sched_r  <= PULSE_SCHED_RST;
      trig_width_r   <= TRIG_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TIMER_PERIOD: timer_period_r <= cfg_data;
        CFG_PULSE_SCHED:  pulse_sched_r  <= cfg_data[SCHED_W-1:0];
        CFG_TRIG_WIDTH:   trig_width_r   <= cfg_data[SCHED_W-1:0];
        default: ;
      endcase
    end
  end

  // Period counter, scheduler and trigger pulse for this tick
  always_comb begin
    period_inc = period_r + 1'b1;
    sched_step = (period_inc == timer_period_r);
    period_nxt = sched_step ? '0 : period_inc;
    fire       = sched_step && (sched_r == pulse_sched_r);
    sched_nxt  = sched_r;
    if (sched_step) begin
      sched_nxt = fire ? '0 : sched_r + 1'b1;
    end
    pulse_ld  = fire ? trig_width_r : pulse_r;
    trig      = (pulse_ld != '0);
    pulse_nxt = trig ? pulse_ld - 1'b1 : pulse_ld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usec_r   <= '0;
      period_r <= '0;
      sched_r  <= '0;
      pulse_r  <= '0;
    end else if (step) begin
      usec_r   <= usec_r + 1'b1;
      period_r <= period_nxt;
      sched_r  <= sched_nxt;
      pulse_r  <= pulse_nxt;
    end
  end

  assign usec = usec_r;

  `URE_ASSERT_NEXT(a_period_restart, step && sched_step, period_r == '0,
    "period counter did not restart on scheduler step")
  `URE_ASSERT_NEXT(a_sched_clear, step && fire, sched_r == '0,
    "schedule count not cleared on trigger firing")

endmodule

/* design/ure_chan.sv */
// One echo channel: edge capture, pulse duration and half-weight average.
// Depends on ure_pkg.
`timescale 1ns / 1ps

module ure_chan import ure_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  echo,
  input  logic [TIME_WIDTH-1:0] usec,
  output logic [DUR_W-1:0]      dur_avg,
  output logic                  fresh
);

  logic                  prev_r;
  logic                  loaded_r;
  logic [TIME_WIDTH-1:0] start_r, start_nxt;
  logic [FILT_W-1:0]     filt_r, filt_nxt;
  logic [TIME_WIDTH-1:0] span;
  logic [DUR_W-1:0]      dur;
  logic [FILT_W:0]       sum;
  logic                  rise;

  // Edge detect, duration and filter update
  always_comb begin
    rise  = echo && !prev_r;
    fresh = !echo && prev_r;
    span  = usec - start_r;
    dur   = (span > TIME_WIDTH'(DUR_MAX)) ? DUR_MAX : span[DUR_W-1:0];
    sum   = {1'b0, filt_r} + {1'b0, dur, 1'b0};
    start_nxt = rise ? usec : start_r;
    filt_nxt  = filt_r;
    if (fresh) begin
      filt_nxt = loaded_r ? sum[FILT_W:1] : {dur, 1'b0};
    end
    dur_avg = filt_nxt[FILT_W-1:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= 1'b0;
      loaded_r <= 1'b0;
      start_r  <= '0;
      filt_r   <= '0;
    end else if (step) begin
      prev_r   <= echo;
      loaded_r <= loaded_r || fresh;
      start_r  <= start_nxt;
      filt_r   <= filt_nxt;
    end
  end

endmodule

/* design/ure_scale.sv */
// Distance scaling lane: D * 32000 / 7347 over four register stages.
// Depends on ure_pkg.
`timescale 1ns / 1ps

module ure_scale import ure_pkg::*; (
  input  logic              clk,
  input  pipe_en_t          en,
  input  logic [DUR_W-1:0]  dur_avg,
  output logic [DIST_W-1:0] distance
);

  logic [DUR_W-1:0]            d_r;
  logic [PROD_W-1:0]           x_r, x3_r;
  logic [DIST_W-1:0]           q0_r, dist_r;
  logic [PROD_W+RECIP_W-1:0]   est;
  logic [REM_W-1:0]            back, rem;

  // Reciprocal estimate and remainder correction
  always_comb begin
    est  = {{RECIP_W{1'b0}}, x_r} * {{PROD_W{1'b0}}, DIST_RECIP};
    back = {{(REM_W-DIST_W){1'b0}}, q0_r} * {{(REM_W-13){1'b0}}, DIST_DEN};
    rem  = {{(REM_W-PROD_W){1'b0}}, x3_r} - back;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      d_r <= dur_avg;
    end
    if (en.s2) begin
      x_r <= PROD_W'(d_r * DIST_NUM);
    end
    if (en.s3) begin
      q0_r <= est[RECIP_SHIFT +: DIST_W];
      x3_r <= x_r;
    end
    if (en.s4) begin
      dist_r <= (rem >= {{(REM_W-13){1'b0}}, DIST_DEN}) ? q0_r + 1'b1 : q0_r;
    end
  end

  assign distance = dist_r;

endmodule

/* design/ultrasonic_echo_ranger.sv */
// Multi-channel ultrasonic ranger: one input word per microsecond tick.
// An accepted input word is registered through stages s1 to s4; s4 drives the result word.
// Throughput: one word per cycle while out_tready is high; the four-stage distance pipeline stalls
// stage by stage when out_tready is low, so bubbles still take input.
// Reset (rst_n, synchronous): counters, echo state and filters clear,
// registers load period 10000, schedule 5, trigger width 10.
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_defines.svh"

module ultrasonic_echo_ranger import ure_pkg::*; #(
  parameter int CHANNELS   = 3,
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // echo level per channel, channel 0 (left) in bit 0, zero padded
  input  logic [((CHANNELS+7)/8)*8-1:0] in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // trigger, dist per channel (19 bits each, left first), fresh_mask, zero padded
  output logic [((1+CHANNELS*(DIST_W+1))+7)/8*8-1:0] out_tdata
);

  localparam int STAGES = 4;

  logic                  in_accept;
  logic [STAGES-1:0]     v_r;
  logic [STAGES:0]       rdy;
  pipe_en_t              en;
  logic [TIME_WIDTH-1:0] usec;
  logic                  trig;
  logic [CHANNELS-1:0]   fresh;
  logic [STAGES-1:0]     trig_r;
  logic [CHANNELS-1:0]   fresh1_r, fresh2_r, fresh3_r, fresh4_r;
  logic [DUR_W-1:0]      dur_avg  [CHANNELS];
  logic [DIST_W-1:0]     distance [CHANNELS];

  assign cfg_ready = 1'b1;

  // Stage-by-stage ready: a stage loads when empty or draining
  always_comb begin
    rdy[STAGES] = out_tready;
    for (int k = STAGES-1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    en.s1 = rdy[0];
    en.s2 = rdy[1];
    en.s3 = rdy[2];
    en.s4 = rdy[3];
  end

  assign in_tready  = rdy[0];
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = v_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Trigger and fresh flags ride alongside the distance lanes
  always_ff @(posedge clk) begin
    if (en.s1) begin
      trig_r[0] <= trig;
      fresh1_r  <= fresh;
    end
    if (en.s2) begin
      trig_r[1] <= trig_r[0];
      fresh2_r  <= fresh1_r;
    end
    if (en.s3) begin
      trig_r[2] <= trig_r[1];
      fresh3_r  <= fresh2_r;
    end
    if (en.s4) begin
      trig_r[3] <= trig_r[2];
      fresh4_r  <= fresh3_r;
    end
  end

  ure_ctrl #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .step     (in_accept),
    .usec     (usec),
    .trig     (trig)
  );

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    ure_chan #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_chan (
      .clk     (clk),
      .rst_n   (rst_n),
      .step    (in_accept),
      .echo    (in_tdata[c]),
      .usec    (usec),
      .dur_avg (dur_avg[c]),
      .fresh   (fresh[c])
    );

    ure_scale u_scale (
      .clk      (clk),
      .en       (en),
      .dur_avg  (dur_avg[c]),
      .distance (distance[c])
    );
  end

  // Result word packing
  always_comb begin
    out_tdata    = '0;
    out_tdata[0] = trig_r[STAGES-1];
    for (int c = 0; c < CHANNELS; c++) begin
      out_tdata[1 + c*DIST_W +: DIST_W] = distance[c];
    end
    out_tdata[1 + CHANNELS*DIST_W +: CHANNELS] = fresh4_r;
  end

  `URE_ASSERT_NOW(a_stall_full, !in_tready, v_r == {STAGES{1'b1}},
    "input stalled while the pipeline has a free stage")
  `URE_ASSERT_NEXT(a_accept_lands, in_accept, v_r[0],
    "accepted word did not enter the first stage")

endmodule
